// ----- rtl/sbps_pkg.sv -----
// ----------------------------------------------------------------------------
// sbps_pkg
// Shared types, codes and helpers of the six-button pad scanner: transfer
// payloads, sequencer steps, pad kinds and the wait-timer load rule.
// ----------------------------------------------------------------------------
package sbps_pkg;

    // timer width of the wait counter
    localparam int TIMER_BITS = 16;
    // width of the configuration registers and of the config write data
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int PORT_W     = 6;
    localparam int BTN_W      = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 1'd1;

    // configuration reset values
    localparam logic [CFG_W-1:0] PULSE_TICKS_RST  = 16'd10;
    localparam logic [CFG_W-1:0] SETTLE_TICKS_RST = 16'd10000;

    // command codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_DETECT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // pad kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SIMPLE = 2'd1;
    localparam logic [1:0] KIND_THREE  = 2'd2;
    localparam logic [1:0] KIND_SIX    = 2'd3;

    // pad line masks
    localparam logic [PORT_W-1:0] LINES_ALL     = 6'h3F;
    localparam logic [PORT_W-1:0] LINES_LR      = 6'h0C;
    localparam logic [PORT_W-1:0] LINES_NIBBLE  = 6'h0F;
    localparam logic [PORT_W-1:0] LINES_AB      = 6'h30;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'd0,
        ST_SP_WAIT   = 5'd1,
        ST_D_OUT     = 5'd2,
        ST_D_HIGH    = 5'd3,
        ST_D_LOW     = 5'd4,
        ST_M1        = 5'd5,
        ST_M2        = 5'd6,
        ST_M3        = 5'd7,
        ST_M4        = 5'd8,
        ST_M5        = 5'd9,
        ST_M6        = 5'd10,
        ST_NONE_WAIT = 5'd11,
        ST_R1        = 5'd12,
        ST_R2        = 5'd13,
        ST_R3        = 5'd14,
        ST_R4        = 5'd15,
        ST_R5        = 5'd16,
        ST_R6        = 5'd17,
        ST_R7        = 5'd18,
        ST_R8        = 5'd19
    } t_seq_step;

    typedef struct packed {
        logic [1:0]        op;
        logic [PORT_W-1:0] pad_port;
        logic              th_active;
    } t_in_item;

    typedef struct packed {
        logic             select_level;
        logic             select_drive;
        logic             switch_on;
        logic [1:0]       pad_kind;
        logic [BTN_W-1:0] buttons;
        logic             busy_res;
        logic             done_res;
    } t_out_item;

    // sequencer state carried between items
    typedef struct packed {
        t_seq_step             seq_step;
        logic [TIMER_BITS-1:0] wait_count;
        logic [BTN_W-1:0]      button_word;
        logic [1:0]            pad_kind;
        logic [PORT_W-1:0]     high_sample;
        logic                  select_lvl;
        logic                  drive;
        logic                  switch_en;
    } t_core_state;

    typedef struct packed {
        logic [CFG_W-1:0] pulse_ticks;
        logic [CFG_W-1:0] settle_ticks;
    } t_cfg;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    // wait load: zero counts as one tick, long waits clamp to the timer top
    function automatic logic [TIMER_BITS-1:0] wait_load(input logic [CFG_W-1:0] ticks);
        logic [CMP_W-1:0] t;
        logic [CMP_W-1:0] top;
        t   = CMP_W'(ticks);
        top = CMP_W'({TIMER_BITS{1'b1}});
        if (t == '0) begin
            t = CMP_W'(1);
        end
        if (t > top) begin
            t = top;
        end
        return t[TIMER_BITS-1:0];
    endfunction

endpackage

// ----- rtl/six_button_pad_scanner.sv -----
// ----------------------------------------------------------------------------
// six_button_pad_scanner
// Timed select-line sequencer that detects the attached pad kind and reads
// a 12-bit button word from a multiplexed six-line pad port.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one command
//   per transfer: tick, start detection or start button read, with the pad
//   lines and the TH flag. Each transfer yields exactly one result transfer
//   (o_out_valid / i_out_ready / o_out_item) showing the select outputs,
//   pad kind, button word and busy/done flags after that item.
//   An accepted item is captured in the input register and passes through
//   the sequencer step logic into the result register. Throughput is one
//   item per cycle while the receiver does not stall, set by the single
//   pass from input to result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; after that o_in_ready drops until
//   the result is taken.
//   Reset (synchronous, active low) empties both registers, returns the
//   sequencer to idle with select high and released, switch off, no pad,
//   and loads the default pulse and settle tick counts.
//   Configuration writes via i_cfg_we / i_cfg_idx / i_cfg_data apply at once.
// ----------------------------------------------------------------------------
module six_button_pad_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sbps_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sbps_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [sbps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sbps_pkg::CFG_W-1:0]          i_cfg_data
);
    import sbps_pkg::*;

    t_cfg        r_cfg;
    t_in_item    r_in;
    logic        r_in_valid;
    t_out_item   r_out;
    logic        r_out_valid;
    t_core_state r_state;
    t_core_state n_state;
    logic        n_done;
    logic        advance;

    // item moves from input register to result register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks  <= PULSE_TICKS_RST;
            r_cfg.settle_ticks <= SETTLE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PULSE_TICKS:  r_cfg.pulse_ticks  <= i_cfg_data;
                CFG_SETTLE_TICKS: r_cfg.settle_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // sequencer step logic
    sbps_step u_step (
        .state_q (r_state),
        .item    (r_in),
        .cfg     (r_cfg),
        .state_d (n_state),
        .done    (n_done)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.seq_step    <= ST_IDLE;
            r_state.wait_count  <= '0;
            r_state.button_word <= '0;
            r_state.pad_kind    <= KIND_NONE;
            r_state.high_sample <= LINES_ALL;
            r_state.select_lvl  <= 1'b1;
            r_state.drive       <= 1'b0;
            r_state.switch_en   <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.select_level <= n_state.select_lvl;
            r_out.select_drive <= n_state.drive;
            r_out.switch_on    <= n_state.switch_en;
            r_out.pad_kind     <= n_state.pad_kind;
            r_out.buttons      <= n_state.button_word;
            r_out.busy_res     <= (n_state.seq_step != ST_IDLE);
            r_out.done_res     <= n_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a running sequence always has a pending wait
    a_wait_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.seq_step != ST_IDLE) |-> (r_state.wait_count != '0))
        else $error("sequencer busy with an empty wait timer");

    // a finished sequence is never reported busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.done_res && r_out.busy_res))
        else $error("result flags done and busy together");

    // the analog switch stays enabled once set
    a_switch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.switch_en |=> r_state.switch_en)
        else $error("analog switch enable dropped");

    // a held input item is not lost while the result side stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled input item lost or changed");

endmodule

// ----- rtl/sbps_step.sv -----
// ----------------------------------------------------------------------------
// sbps_step
// Next-state logic of the pad scanner sequencer: one item in, the state that
// follows it and the done flag out.
// ----------------------------------------------------------------------------
module sbps_step (
    input  sbps_pkg::t_core_state state_q,
    input  sbps_pkg::t_in_item    item,
    input  sbps_pkg::t_cfg        cfg,
    output sbps_pkg::t_core_state state_d,
    output logic                  done
);
    import sbps_pkg::*;

    logic [TIMER_BITS-1:0] dec_count;
    logic [TIMER_BITS-1:0] pulse_load;
    logic [TIMER_BITS-1:0] settle_load;
    logic [PORT_W-1:0]     port_n;

    assign pulse_load  = wait_load(cfg.pulse_ticks);
    assign settle_load = wait_load(cfg.settle_ticks);
    assign port_n      = ~item.pad_port;
    assign dec_count   = (state_q.wait_count != '0) ? state_q.wait_count - 1'b1
                                                    : state_q.wait_count;

    // command start, timer advance and step actions
    always_comb begin
        state_d = state_q;
        done    = 1'b0;
        if (state_q.seq_step == ST_IDLE && item.op == OP_DETECT) begin
            state_d.wait_count = settle_load;
            if (item.th_active) begin
                state_d.drive    = 1'b0;
                state_d.seq_step = ST_SP_WAIT;
            end else begin
                state_d.drive    = 1'b1;
                state_d.seq_step = ST_D_OUT;
            end
        end else if (state_q.seq_step == ST_IDLE && item.op == OP_READ) begin
            state_d.select_lvl = 1'b1;
            state_d.wait_count = settle_load;
            state_d.seq_step   = ST_R1;
        end else if (state_q.seq_step != ST_IDLE) begin
            state_d.wait_count = dec_count;
            if (dec_count == '0) begin
                case (state_q.seq_step)
                    ST_SP_WAIT: begin
                        state_d.switch_en = 1'b1;
                        state_d.pad_kind  = KIND_SIMPLE;
                        done              = 1'b1;
                    end
                    ST_D_OUT: begin
                        state_d.select_lvl = 1'b1;
                        state_d.wait_count = settle_load;
                        state_d.seq_step   = ST_D_HIGH;
                    end
                    ST_D_HIGH: begin
                        state_d.high_sample = item.pad_port;
                        state_d.select_lvl  = 1'b0;
                        state_d.wait_count  = pulse_load;
                        state_d.seq_step    = ST_D_LOW;
                    end
                    ST_D_LOW: begin
                        if ((item.pad_port & LINES_LR) == '0) begin
                            state_d.pad_kind   = KIND_THREE;
                            state_d.select_lvl = 1'b1;
                            state_d.wait_count = pulse_load;
                            state_d.seq_step   = ST_M1;
                        end else begin
                            state_d.drive      = 1'b0;
                            state_d.wait_count = settle_load;
                            state_d.seq_step   = (state_q.high_sample != LINES_ALL)
                                                 ? ST_SP_WAIT : ST_NONE_WAIT;
                        end
                    end
                    ST_M1, ST_M3: begin
                        state_d.select_lvl = 1'b0;
                        state_d.wait_count = pulse_load;
                        state_d.seq_step   = (state_q.seq_step == ST_M1) ? ST_M2 : ST_M4;
                    end
                    ST_M2: begin
                        state_d.select_lvl = 1'b1;
                        state_d.wait_count = pulse_load;
                        state_d.seq_step   = ST_M3;
                    end
                    ST_M4: begin
                        if ((item.pad_port & LINES_NIBBLE) == '0) begin
                            state_d.select_lvl = 1'b1;
                            state_d.wait_count = pulse_load;
                            state_d.seq_step   = ST_M5;
                        end else begin
                            state_d.select_lvl = 1'b1;
                            done               = 1'b1;
                        end
                    end
                    ST_M5: begin
                        state_d.select_lvl = 1'b0;
                        state_d.wait_count = pulse_load;
                        state_d.seq_step   = ST_M6;
                    end
                    ST_M6: begin
                        if ((item.pad_port & LINES_NIBBLE) == LINES_NIBBLE) begin
                            state_d.pad_kind = KIND_SIX;
                        end
                        state_d.select_lvl = 1'b1;
                        done               = 1'b1;
                    end
                    ST_R1: begin
                        state_d.button_word[5:0] = port_n;
                        state_d.select_lvl       = 1'b0;
                        state_d.wait_count       = pulse_load;
                        state_d.seq_step         = ST_R2;
                    end
                    ST_R2: begin
                        state_d.button_word[7:6] = port_n[5:4];
                        state_d.select_lvl       = 1'b1;
                        if (state_q.pad_kind == KIND_SIX) begin
                            state_d.wait_count = pulse_load;
                            state_d.seq_step   = ST_R3;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    ST_R3, ST_R5: begin
                        state_d.select_lvl = 1'b0;
                        state_d.wait_count = pulse_load;
                        state_d.seq_step   = (state_q.seq_step == ST_R3) ? ST_R4 : ST_R6;
                    end
                    ST_R4, ST_R6: begin
                        state_d.select_lvl = 1'b1;
                        state_d.wait_count = pulse_load;
                        state_d.seq_step   = (state_q.seq_step == ST_R4) ? ST_R5 : ST_R7;
                    end
                    ST_R7: begin
                        state_d.button_word[11:8] = port_n[3:0];
                        state_d.select_lvl        = 1'b0;
                        state_d.wait_count        = pulse_load;
                        state_d.seq_step          = ST_R8;
                    end
                    ST_R8: begin
                        state_d.select_lvl = 1'b1;
                        done               = 1'b1;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
                // a finished sequence returns to idle with the timer cleared
                if (done) begin
                    state_d.seq_step   = ST_IDLE;
                    state_d.wait_count = '0;
                end
            end
        end
    end

endmodule

// ----- sim/pad_scanner_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pad_scanner_checker
// Watches both transfer channels and the register write port of the pad
// scanner, predicts the report that each accepted command gives, and
// compares every returned report against the oldest prediction, field by
// field. Hands the failure count, the pending report count, the predicted busy flag and pad kind to the top.
// ----------------------------------------------------------------------------
module pad_scanner_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  sbps_pkg::t_in_item             i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  sbps_pkg::t_out_item            i_out_item,
    input  logic                           i_cfg_we,
    input  logic [sbps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sbps_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output logic                           o_model_busy,
    output logic [1:0]                     o_model_kind
);
    import sbps_pkg::*;

    // predicted sequencer state
    t_seq_step             step;
    logic [TIMER_BITS-1:0] ticks_left;
    logic [BTN_W-1:0]      btn_word;
    logic [1:0]            kind;
    logic [PORT_W-1:0]     high_lines;
    logic                  sel_level;
    logic                  sel_drive;
    logic                  switch_en;

    // predicted timing registers
    logic [CFG_W-1:0]      pulse_cfg;
    logic [CFG_W-1:0]      settle_cfg;

    // reports still owed by the block, oldest first
    t_out_item             owed_reports[$];
    int                    fails = 0;

    // load the wait timer: zero means one tick, overlong waits saturate
    function automatic void arm_timer(input t_seq_step next, input logic [CFG_W-1:0] ticks);
        longint unsigned span;
        longint unsigned timer_top;
        timer_top = (longint'(1) << TIMER_BITS) - 1;
        span      = ticks;
        if (span == 0) begin
            span = 1;
        end
        if (span > timer_top) begin
            span = timer_top;
        end
        ticks_left = TIMER_BITS'(span);
        step       = next;
    endfunction

    // move the select line and wait one pulse period
    function automatic void pulse_select(input t_seq_step next, input logic level);
        sel_level = level;
        arm_timer(next, pulse_cfg);
    endfunction

    // action of the step whose wait has just run out; 1 when the sequence ends
    function automatic logic run_step(input logic [PORT_W-1:0] lines);
        case (step)
            ST_SP_WAIT: begin
                switch_en = 1'b1;
                kind      = KIND_SIMPLE;
                return 1'b1;
            end
            ST_D_OUT: begin
                sel_level = 1'b1;
                arm_timer(ST_D_HIGH, settle_cfg);
            end
            ST_D_HIGH: begin
                high_lines = lines;
                pulse_select(ST_D_LOW, 1'b0);
            end
            ST_D_LOW: begin
                // left and right both low with select low: multi-button pad
                if ((lines & LINES_LR) == '0) begin
                    kind = KIND_THREE;
                    pulse_select(ST_M1, 1'b1);
                end else begin
                    sel_drive = 1'b0;
                    if (high_lines != LINES_ALL) begin
                        arm_timer(ST_SP_WAIT, settle_cfg);
                    end else begin
                        arm_timer(ST_NONE_WAIT, settle_cfg);
                    end
                end
            end
            ST_M1: pulse_select(ST_M2, 1'b1 ^ 1'b1);
            ST_M2: pulse_select(ST_M3, 1'b1);
            ST_M3: pulse_select(ST_M4, 1'b0);
            ST_M4: begin
                if ((lines & LINES_NIBBLE) == '0) begin
                    pulse_select(ST_M5, 1'b1);
                end else begin
                    sel_level = 1'b1;
                    return 1'b1;
                end
            end
            ST_M5: pulse_select(ST_M6, 1'b0);
            ST_M6: begin
                if ((lines & LINES_NIBBLE) == LINES_NIBBLE) begin
                    kind = KIND_SIX;
                end
                sel_level = 1'b1;
                return 1'b1;
            end
            ST_NONE_WAIT: return 1'b1;
            ST_R1: begin
                btn_word[5:0] = ~lines;
                pulse_select(ST_R2, 1'b0);
            end
            ST_R2: begin
                btn_word[7:6] = ~lines[5:4];
                if (kind == KIND_SIX) begin
                    pulse_select(ST_R3, 1'b1);
                end else begin
                    sel_level = 1'b1;
                    return 1'b1;
                end
            end
            ST_R3: pulse_select(ST_R4, 1'b0);
            ST_R4: pulse_select(ST_R5, 1'b1);
            ST_R5: pulse_select(ST_R6, 1'b0);
            ST_R6: pulse_select(ST_R7, 1'b1);
            ST_R7: begin
                btn_word[11:8] = ~lines[3:0];
                pulse_select(ST_R8, 1'b0);
            end
            ST_R8: begin
                sel_level = 1'b1;
                return 1'b1;
            end
            default: return 1'b1;
        endcase
        return 1'b0;
    endfunction

    // advance the predicted scanner by one command, give the report it owes
    function automatic t_out_item scan_item(input t_in_item cmd);
        t_out_item report;
        logic      finished;
        finished = 1'b0;
        if (step == ST_IDLE && cmd.op == OP_DETECT) begin
            if (cmd.th_active) begin
                sel_drive = 1'b0;
                arm_timer(ST_SP_WAIT, settle_cfg);
            end else begin
                sel_drive = 1'b1;
                arm_timer(ST_D_OUT, settle_cfg);
            end
        end else if (step == ST_IDLE && cmd.op == OP_READ) begin
            sel_level = 1'b1;
            arm_timer(ST_R1, settle_cfg);
        end else if (step != ST_IDLE) begin
            // commands while busy and the spare code all count as ticks
            if (ticks_left != '0) begin
                ticks_left = ticks_left - 1'b1;
            end
            if (ticks_left == '0) begin
                if (run_step(cmd.pad_port)) begin
                    step       = ST_IDLE;
                    ticks_left = '0;
                    finished   = 1'b1;
                end
            end
        end
        report.select_level = sel_level;
        report.select_drive = sel_drive;
        report.switch_on    = switch_en;
        report.pad_kind     = kind;
        report.buttons      = btn_word;
        report.busy_res     = (step != ST_IDLE);
        report.done_res     = finished;
        return report;
    endfunction

    task automatic check_field(input string name, input logic [BTN_W-1:0] want,
                               input logic [BTN_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    // watch the channels: results are checked before the new command is predicted
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            step       = ST_IDLE;
            ticks_left = '0;
            btn_word   = '0;
            kind       = KIND_NONE;
            high_lines = LINES_ALL;
            sel_level  = 1'b1;
            sel_drive  = 1'b0;
            switch_en  = 1'b0;
            pulse_cfg  = PULSE_TICKS_RST;
            settle_cfg = SETTLE_TICKS_RST;
            owed_reports.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PULSE_TICKS) begin
                    pulse_cfg = i_cfg_data;
                end else if (i_cfg_idx == CFG_SETTLE_TICKS) begin
                    settle_cfg = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_reports.size() == 0) begin
                    $error("report transfer with no command waiting for it");
                    fails++;
                end else begin
                    want = owed_reports.pop_front();
                    check_field("select_level", want.select_level, i_out_item.select_level);
                    check_field("select_drive", want.select_drive, i_out_item.select_drive);
                    check_field("switch_on", want.switch_on, i_out_item.switch_on);
                    check_field("pad_kind", want.pad_kind, i_out_item.pad_kind);
                    check_field("buttons", want.buttons, i_out_item.buttons);
                    check_field("busy_res", want.busy_res, i_out_item.busy_res);
                    check_field("done_res", want.done_res, i_out_item.done_res);
                end
            end
            if (i_in_valid && i_in_ready) begin
                owed_reports.push_back(scan_item(i_in_item));
            end
        end
        o_pending    <= owed_reports.size();
        o_model_busy <= (step != ST_IDLE);
        o_model_kind <= kind;
        o_fail_count <= fails;
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the six-button pad scanner: scripted detection and read
// sequences that answer each sampling tick with chosen pad lines, random
// filler commands inside the waits, loose noise, timing register sweeps
// from zero up to long waits, and random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import sbps_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_ITEMS   = 900;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_PULSE_TICKS;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int                   fail_count;
    int                   pending;
    logic                 model_busy;
    logic [1:0]           model_kind;

    bit                   idle_en      = 1'b0;
    int                   stall_cnt    = 0;
    int                   quiet_cycles = 0;
    int                   items_sent   = 0;
    logic [CFG_W-1:0]     pulse_now    = PULSE_TICKS_RST;
    logic [CFG_W-1:0]     settle_now   = SETTLE_TICKS_RST;

    six_button_pad_scanner DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pad_scanner_checker report_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_model_busy (model_busy),
        .o_model_kind (model_kind)
    );

    // clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // random receiver stalls, only while idling is enabled
    always @(posedge clk) begin : receiver_stalls
        int n_stall;
        n_stall = stall_cnt;
        if (n_stall > 0) begin
            n_stall--;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            n_stall = $urandom_range(1, 12);
        end
        stall_cnt <= n_stall;
        out_ready <= (n_stall == 0);
    end

    // cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // timer width equals register width here, so only the zero rule applies
    function automatic int unsigned wait_len(input logic [CFG_W-1:0] ticks);
        return (ticks == '0) ? 1 : int'(ticks);
    endfunction

    // one command transfer, with an occasional sender gap in front
    task automatic send_item(input logic [1:0] op, input logic [PORT_W-1:0] lines,
                             input logic th);
        t_in_item cmd;
        cmd.op        = op;
        cmd.pad_port  = lines;
        cmd.th_active = th;
        if (idle_en && $urandom_range(0, 11) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= cmd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // hold off until every report is back and the sequencer has gone idle
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || model_busy) begin
            if (pending != 0) begin
                @(posedge clk);
            end else begin
                send_item(OP_TICK, PORT_W'($urandom), 1'($urandom));
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // filler ticks (any code, the sequencer is busy) then the tick that ends the wait
    task automatic step_after(input logic [CFG_W-1:0] ticks, input logic [PORT_W-1:0] lines);
        repeat (wait_len(ticks) - 1) begin
            send_item(2'($urandom_range(0, 3)), PORT_W'($urandom), 1'($urandom));
        end
        send_item(2'($urandom_range(0, 3)), lines, 1'($urandom));
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] settle);
        quiesce();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_PULSE_TICKS;
        cfg_data <= pulse;
        @(posedge clk);
        cfg_idx  <= CFG_SETTLE_TICKS;
        cfg_data <= settle;
        @(posedge clk);
        cfg_we     <= 1'b0;
        pulse_now  = pulse;
        settle_now = settle;
    endtask

    // detection, answering each sampling tick with the given lines
    task automatic detect_pad(input logic th, input logic [PORT_W-1:0] high_lines,
                              input logic [PORT_W-1:0] low_lines,
                              input logic [PORT_W-1:0] probe_lines,
                              input logic [PORT_W-1:0] six_lines);
        quiesce();
        send_item(OP_DETECT, PORT_W'($urandom), th);
        if (th) begin
            step_after(settle_now, PORT_W'($urandom));
        end else begin
            step_after(settle_now, PORT_W'($urandom));
            step_after(settle_now, high_lines);
            step_after(pulse_now, low_lines);
            if ((low_lines & LINES_LR) == '0) begin
                repeat (3) step_after(pulse_now, PORT_W'($urandom));
                step_after(pulse_now, probe_lines);
                if ((probe_lines & LINES_NIBBLE) == '0) begin
                    step_after(pulse_now, PORT_W'($urandom));
                    step_after(pulse_now, six_lines);
                end
            end else begin
                step_after(settle_now, PORT_W'($urandom));
            end
        end
    endtask

    // button read; the six-button phase only runs for a six-button pad
    task automatic read_pad(input logic [PORT_W-1:0] high_lines,
                            input logic [PORT_W-1:0] low_lines,
                            input logic [PORT_W-1:0] extra_lines);
        logic [1:0] kind_now;
        quiesce();
        kind_now = model_kind;
        send_item(OP_READ, PORT_W'($urandom), 1'($urandom));
        step_after(settle_now, high_lines);
        step_after(pulse_now, low_lines);
        if (kind_now == KIND_SIX) begin
            repeat (4) step_after(pulse_now, PORT_W'($urandom));
            step_after(pulse_now, extra_lines);
            step_after(pulse_now, PORT_W'($urandom));
        end
    endtask

    initial begin : stimulus
        int random_start;
        logic [CFG_W-1:0] pulse_pick;
        logic [CFG_W-1:0] settle_pick;
        int pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle ticks and the spare code before any sequence has run
        send_item(OP_TICK, 6'h00, 1'b0);
        send_item(2'd3, LINES_ALL, 1'b1);

        // directed detection and read cases on the shortest timing
        set_timing(16'd1, 16'd1);
        read_pad(6'h00, LINES_ALL, 6'h00);
        detect_pad(1'b1, 6'h00, 6'h00, 6'h00, 6'h00);
        detect_pad(1'b0, LINES_ALL, LINES_ALL, 6'h00, 6'h00);
        detect_pad(1'b0, 6'h15, LINES_LR, 6'h00, 6'h00);
        detect_pad(1'b0, LINES_ALL, 6'h00, 6'h00, LINES_NIBBLE);
        read_pad(6'h00, 6'h00, 6'h00);
        read_pad(LINES_ALL, LINES_ALL, LINES_ALL);
        detect_pad(1'b0, LINES_ALL, 6'h33, 6'h05, 6'h00);
        detect_pad(1'b0, 6'h2A, 6'h30, 6'h30, 6'h07);
        read_pad(6'h2A, 6'h15, 6'h00);

        // zero in both timing registers counts as one tick
        set_timing(16'd0, 16'd0);
        detect_pad(1'b0, LINES_ALL, 6'h00, 6'h00, LINES_ALL);
        read_pad(6'h3C, 6'h03, 6'h0A);

        // random phases, each on its own short timing
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            pulse_pick  = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
            settle_pick = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            set_timing(pulse_pick, settle_pick);
            idle_en = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) begin
                pick = $urandom_range(0, 19);
                if (pick < 8) begin
                    detect_pad(($urandom_range(0, 4) == 0),
                               ($urandom_range(0, 1) == 0) ? LINES_ALL : PORT_W'($urandom),
                               ($urandom_range(0, 4) < 3) ? (PORT_W'($urandom) & ~LINES_LR)
                                                          : PORT_W'($urandom),
                               ($urandom_range(0, 4) < 3) ? (PORT_W'($urandom) & ~LINES_NIBBLE)
                                                          : PORT_W'($urandom),
                               ($urandom_range(0, 4) < 3) ? (PORT_W'($urandom) | LINES_NIBBLE)
                                                          : PORT_W'($urandom));
                end else if (pick < 16) begin
                    read_pad(PORT_W'($urandom), PORT_W'($urandom), PORT_W'($urandom));
                end else begin
                    // loose commands and ticks with no script behind them
                    repeat ($urandom_range(1, 6)) begin
                        send_item(2'($urandom_range(0, 3)), PORT_W'($urandom), 1'($urandom));
                    end
                end
            end
        end

        // long waits, no idling from here on
        idle_en = 1'b0;
        set_timing(16'd1, 16'd150);
        detect_pad(1'b1, 6'h00, 6'h00, 6'h00, 6'h00);
        set_timing(16'd150, 16'd1);
        detect_pad(1'b0, LINES_ALL, LINES_ALL, 6'h00, 6'h00);

        quiesce();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sbps_pkg.sv
rtl/sbps_step.sv
rtl/six_button_pad_scanner.sv
sim/pad_scanner_checker.sv
sim/tb.sv
